### hw/rtl/rse_pkg.sv
// Shared types and constants for the RV32 subset executor.
// Operation codes, the byte-memory request type and the execute result type.
// No dependencies.
package rse_pkg;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_SUB  = 5'd1;
    localparam logic [4:0] OP_AND  = 5'd2;
    localparam logic [4:0] OP_OR   = 5'd3;
    localparam logic [4:0] OP_XOR  = 5'd4;
    localparam logic [4:0] OP_SLT  = 5'd5;
    localparam logic [4:0] OP_SLL  = 5'd6;
    localparam logic [4:0] OP_SRA  = 5'd7;
    localparam logic [4:0] OP_ADDI = 5'd8;
    localparam logic [4:0] OP_ANDI = 5'd9;
    localparam logic [4:0] OP_ORI  = 5'd10;
    localparam logic [4:0] OP_XORI = 5'd11;
    localparam logic [4:0] OP_SLTI = 5'd12;
    localparam logic [4:0] OP_LW   = 5'd13;
    localparam logic [4:0] OP_LB   = 5'd14;
    localparam logic [4:0] OP_SW   = 5'd15;
    localparam logic [4:0] OP_SB   = 5'd16;
    localparam logic [4:0] OP_LUI  = 5'd17;

    // Byte-memory request: one access per cycle, off is the byte lane of the base address
    typedef struct packed {
        logic       en;
        logic       wr;
        logic       word;
        logic [1:0] off;
    } mem_ctl_t;

    // Execute result of one instruction
    typedef struct packed {
        logic        reg_wr;
        logic        load;
        logic        load_byte;
        logic        store;
        logic        store_word;
        logic        mem;
        logic [31:0] value;
        logic [31:0] addr;
    } alu_res_t;

    function automatic logic is_store(input logic [4:0] mode);
        return (mode == OP_SW) || (mode == OP_SB);
    endfunction

endpackage

### hw/rtl/rse_regfile.sv
// 32 x 32-bit register file, two synchronous read ports and one write port.
// Valid bits make unwritten entries read zero after reset. Uses rse_pkg.
module rse_regfile (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [4:0]  rd_addr_a,
    input  logic [4:0]  rd_addr_b,
    output logic [31:0] rd_data_a,
    output logic [31:0] rd_data_b,
    input  logic        wr_en,
    input  logic [4:0]  wr_addr,
    input  logic [31:0] wr_data
);
    import rse_pkg::*;

    logic [31:0] mem [32];
    logic [31:0] valid_reg;
    logic [31:0] q_a_reg;
    logic [31:0] q_b_reg;
    logic        qv_a_reg;
    logic        qv_b_reg;

    // Read returns the contents before a write at the same edge
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_a_reg <= mem[rd_addr_a];
        q_b_reg <= mem[rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            qv_a_reg  <= 1'b0;
            qv_b_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            qv_a_reg <= valid_reg[rd_addr_a];
            qv_b_reg <= valid_reg[rd_addr_b];
        end
    end

    assign rd_data_a = qv_a_reg ? q_a_reg : '0;
    assign rd_data_b = qv_b_reg ? q_b_reg : '0;

endmodule

### hw/rtl/rse_bytemem.sv
// Byte memory built from four byte-lane memories, one row of four bytes each.
// Holds a clearing pass after reset and rotates bytes for unaligned words. Uses rse_pkg.
module rse_bytemem #(
    parameter int MEM_BYTES = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rse_pkg::mem_ctl_t               ctl,
    input  logic [$clog2(MEM_BYTES/4)-1:0]  row,
    input  logic [31:0]                     wdata,
    output logic [31:0]                     rdata,
    output logic                            busy
);
    import rse_pkg::*;

    localparam int ROWS  = MEM_BYTES / 4;
    localparam int ROW_W = $clog2(ROWS);

    logic [ROW_W-1:0] clr_cnt_reg;
    logic [ROW_W-1:0] clr_cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic [1:0]       off_reg;
    logic [31:0]      wrot;
    logic [31:0]      q_word;
    logic             rd_en;

    assign rd_en = !busy_reg && ctl.en && !ctl.wr;

    // Byte i of the word goes to lane (off + i)
    always_comb
    begin
        case (ctl.off)
            2'd0:    wrot = wdata;
            2'd1:    wrot = {wdata[23:0], wdata[31:24]};
            2'd2:    wrot = {wdata[15:0], wdata[31:16]};
            2'd3:    wrot = {wdata[7:0],  wdata[31:8]};
            default: wrot = wdata;
        endcase
    end

    genvar ln;
    generate
        for (ln = 0; ln < 4; ln++)
        begin : g_lane
            logic [7:0]       lane_mem [ROWS];
            logic [7:0]       q_reg;
            logic [ROW_W-1:0] lane_row;
            logic [ROW_W-1:0] acc_row;
            logic [7:0]       lane_wd;
            logic             lane_we;

            // Lanes below the base lane belong to the next row, wrapping at the end
            assign lane_row = (2'(ln) < ctl.off) ? row + ROW_W'(1) : row;
            assign acc_row  = busy_reg ? clr_cnt_reg : lane_row;
            assign lane_wd  = busy_reg ? 8'h00 : wrot[8*ln +: 8];
            assign lane_we  = busy_reg ||
                              (ctl.en && ctl.wr && (ctl.word || (ctl.off == 2'(ln))));

            always_ff @(posedge clk)
            begin
                if (lane_we)
                begin
                    lane_mem[acc_row] <= lane_wd;
                end
                if (rd_en)
                begin
                    q_reg <= lane_mem[acc_row];
                end
            end

            assign q_word[8*ln +: 8] = q_reg;
        end
    endgenerate

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + ROW_W'(1);
            if (clr_cnt_reg == ROW_W'(ROWS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
            off_reg     <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            busy_reg    <= busy_next;
            if (rd_en)
            begin
                off_reg <= ctl.off;
            end
        end
    end

    // Byte i of the result comes from lane (off + i)
    always_comb
    begin
        case (off_reg)
            2'd0:    rdata = q_word;
            2'd1:    rdata = {q_word[7:0],  q_word[31:8]};
            2'd2:    rdata = {q_word[15:0], q_word[31:16]};
            2'd3:    rdata = {q_word[23:0], q_word[31:24]};
            default: rdata = q_word;
        endcase
    end

    assign busy = busy_reg;

endmodule

### hw/rtl/rse_alu.sv
// Execute unit: arithmetic, logic, shifts, compare and address generation.
// Purely combinational. Uses rse_pkg.
module rse_alu (
    input  logic [4:0]          mode,
    input  logic [31:0]         op_a,
    input  logic [31:0]         op_b,
    input  logic [19:0]         immediate,
    output rse_pkg::alu_res_t   res
);
    import rse_pkg::*;

    logic [31:0] imm_sext;
    logic [31:0] sum_imm;

    assign imm_sext = {{20{immediate[11]}}, immediate[11:0]};
    assign sum_imm  = op_a + imm_sext;

    always_comb
    begin
        res      = '0;
        res.addr = sum_imm;
        case (mode)
            OP_ADD:  begin res.value = op_a + op_b; res.reg_wr = 1'b1; end
            OP_SUB:  begin res.value = op_a - op_b; res.reg_wr = 1'b1; end
            OP_AND:  begin res.value = op_a & op_b; res.reg_wr = 1'b1; end
            OP_OR:   begin res.value = op_a | op_b; res.reg_wr = 1'b1; end
            OP_XOR:  begin res.value = op_a ^ op_b; res.reg_wr = 1'b1; end
            OP_SLT:
            begin
                res.value  = {31'd0, $signed(op_a) < $signed(op_b)};
                res.reg_wr = 1'b1;
            end
            OP_SLL:  begin res.value = op_a << op_b[4:0]; res.reg_wr = 1'b1; end
            OP_SRA:
            begin
                res.value  = $unsigned($signed(op_a) >>> op_b[4:0]);
                res.reg_wr = 1'b1;
            end
            OP_ADDI: begin res.value = sum_imm; res.reg_wr = 1'b1; end
            OP_ANDI: begin res.value = op_a & imm_sext; res.reg_wr = 1'b1; end
            OP_LW:   begin res.mem = 1'b1; res.load = 1'b1; res.reg_wr = 1'b1; end
            OP_LB:
            begin
                res.mem       = 1'b1;
                res.load      = 1'b1;
                res.load_byte = 1'b1;
                res.reg_wr    = 1'b1;
            end
            OP_SW:
            begin
                res.mem        = 1'b1;
                res.store      = 1'b1;
                res.store_word = 1'b1;
                res.value      = op_b;
            end
            OP_SB:   begin res.mem = 1'b1; res.store = 1'b1; res.value = op_b; end
            OP_LUI:  begin res.value = {immediate, 12'd0}; res.reg_wr = 1'b1; end
            default: res.reg_wr = 1'b0;
        endcase
    end

endmodule

### hw/rtl/rv32_subset_executor.sv
// RV32 subset executor: takes one decoded instruction per input item and returns one
// result item describing its register write and memory access. Instructions flow through
// two stages: execute (register operands read from a synchronous register file, with
// forwarding from the result stage and from the write of the previous cycle) and result
// (the output register, where loads collect their data and the register file is written
// when the result item is taken). The sustained rate is one item per cycle while results
// are taken; an item whose source register is the destination of the load just ahead of
// it waits in the execute stage until that load leaves the result stage, as the byte
// memory read is registered. The byte memory is four byte-lane memories; after reset a
// clearing pass zeroes one row of four bytes per cycle, and no item is accepted until it
// ends. MEM_BYTES must be a power of two; addresses wrap at it.
// Depends on rse_pkg, rse_regfile, rse_bytemem and rse_alu.
module rv32_subset_executor #(
    parameter int MEM_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[4:0], dest_reg[9:5], src_reg_a[14:10],
                                   // src_reg_b[19:15], immediate[39:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // reg_written[0], written_index[5:1],
                                   // written_value[37:6], mem_written[38],
                                   // mem_address[50:39], zero fill[55:51]
);
    import rse_pkg::*;

    localparam int          ROW_W     = $clog2(MEM_BYTES / 4);
    localparam logic [31:0] ADDR_MASK = 32'(MEM_BYTES - 1);

    // Input item fields
    logic [4:0]  in_mode;
    logic [4:0]  in_dest_reg;
    logic [4:0]  in_src_reg_a;
    logic [4:0]  in_src_reg_b;
    logic [19:0] in_immediate;

    assign in_mode      = s_tdata[4:0];
    assign in_dest_reg  = s_tdata[9:5];
    assign in_src_reg_a = s_tdata[14:10];
    assign in_src_reg_b = s_tdata[19:15];
    assign in_immediate = s_tdata[39:20];

    // Execute stage
    logic        s1_valid_reg;
    logic [4:0]  s1_mode_reg;
    logic [4:0]  s1_rd_reg;
    logic [4:0]  s1_ra_reg;
    logic [4:0]  s1_rb_reg;
    logic [19:0] s1_imm_reg;

    // Result stage
    logic        s2_valid_reg;
    logic        s2_wr_reg;
    logic [4:0]  s2_rd_reg;
    logic [31:0] s2_value_reg;
    logic        s2_load_reg;
    logic        s2_lb_reg;
    logic        s2_mw_reg;
    logic [11:0] s2_addr_reg;

    // Register write of the previous edge, for reads issued at that same edge
    logic        wbl_valid_reg;
    logic [4:0]  wbl_rd_reg;
    logic [31:0] wbl_value_reg;

    logic        s_accept;
    logic        s2_free;
    logic        stall_ld;
    logic        s1_adv;
    logic        s1_hold;
    logic [4:0]  s1_rb2;
    logic [4:0]  rf_addr_a;
    logic [4:0]  rf_addr_b;
    logic [31:0] rf_data_a;
    logic [31:0] rf_data_b;
    logic [31:0] fwd_a;
    logic [31:0] fwd_b;
    logic        rf_we;
    logic [31:0] wr_value;
    logic [31:0] ld_value;
    logic [31:0] mem_rdata;
    logic        mem_busy;
    logic [31:0] addr_wrap;
    logic        s1_reg_wr;
    alu_res_t    alu_res;
    mem_ctl_t    mem_ctl;

    // Stores read their data register through the second port
    assign s1_rb2 = is_store(s1_mode_reg) ? s1_rd_reg : s1_rb_reg;

    // Hold: a load in the result stage whose data the execute stage needs
    assign stall_ld = s2_valid_reg && s2_wr_reg && s2_load_reg &&
                      ((s2_rd_reg == s1_ra_reg) || (s2_rd_reg == s1_rb2));
    assign s2_free  = !s2_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && s2_free && !stall_ld;
    assign s1_hold  = s1_valid_reg && !s1_adv;
    assign s_tready = !mem_busy && (!s1_valid_reg || s1_adv);
    assign s_accept = s_tvalid && s_tready;

    // Re-read the held item's registers each cycle so later writes are seen
    assign rf_addr_a = s1_hold ? s1_ra_reg : in_src_reg_a;
    assign rf_addr_b = s1_hold ? s1_rb2 :
                       (is_store(in_mode) ? in_dest_reg : in_src_reg_b);

    rse_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr_a (rf_addr_a),
        .rd_addr_b (rf_addr_b),
        .rd_data_a (rf_data_a),
        .rd_data_b (rf_data_b),
        .wr_en     (rf_we),
        .wr_addr   (s2_rd_reg),
        .wr_data   (wr_value)
    );

    // Forward: result stage first, then the write of the last edge, then the file
    always_comb
    begin
        fwd_a = rf_data_a;
        if (s2_valid_reg && s2_wr_reg && !s2_load_reg && (s2_rd_reg == s1_ra_reg))
        begin
            fwd_a = s2_value_reg;
        end
        else if (wbl_valid_reg && (wbl_rd_reg == s1_ra_reg))
        begin
            fwd_a = wbl_value_reg;
        end

        fwd_b = rf_data_b;
        if (s2_valid_reg && s2_wr_reg && !s2_load_reg && (s2_rd_reg == s1_rb2))
        begin
            fwd_b = s2_value_reg;
        end
        else if (wbl_valid_reg && (wbl_rd_reg == s1_rb2))
        begin
            fwd_b = wbl_value_reg;
        end
    end

    rse_alu u_alu (
        .mode      (s1_mode_reg),
        .op_a      (fwd_a),
        .op_b      (fwd_b),
        .immediate (s1_imm_reg),
        .res       (alu_res)
    );

    assign addr_wrap = alu_res.addr & ADDR_MASK;
    assign s1_reg_wr = alu_res.reg_wr && (s1_rd_reg != 5'd0);

    // Issue the memory access as the item leaves the execute stage
    assign mem_ctl.en   = s1_adv && alu_res.mem;
    assign mem_ctl.wr   = alu_res.store;
    assign mem_ctl.word = alu_res.store_word;
    assign mem_ctl.off  = addr_wrap[1:0];

    rse_bytemem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_bytemem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .row   (addr_wrap[ROW_W+1:2]),
        .wdata (alu_res.value),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    assign ld_value = s2_lb_reg ? {{24{mem_rdata[7]}}, mem_rdata[7:0]} : mem_rdata;
    assign wr_value = s2_load_reg ? (s2_wr_reg ? ld_value : 32'd0) : s2_value_reg;
    assign rf_we    = s2_valid_reg && m_tready && s2_wr_reg;

    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = {5'd0, s2_addr_reg, s2_mw_reg, wr_value, s2_rd_reg, s2_wr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            wbl_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || s1_adv)
            begin
                s1_valid_reg <= s_accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_adv;
            end
            wbl_valid_reg <= rf_we;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_mode_reg <= in_mode;
            s1_rd_reg   <= in_dest_reg;
            s1_ra_reg   <= in_src_reg_a;
            s1_rb_reg   <= in_src_reg_b;
            s1_imm_reg  <= in_immediate;
        end
        if (s1_adv)
        begin
            s2_wr_reg    <= s1_reg_wr;
            s2_rd_reg    <= s1_reg_wr ? s1_rd_reg : 5'd0;
            s2_value_reg <= (s1_reg_wr && !alu_res.load) ? alu_res.value : 32'd0;
            s2_load_reg  <= alu_res.load;
            s2_lb_reg    <= alu_res.load_byte;
            s2_mw_reg    <= alu_res.store;
            s2_addr_reg  <= alu_res.mem ? addr_wrap[11:0] : 12'd0;
        end
        if (rf_we)
        begin
            wbl_rd_reg    <= s2_rd_reg;
            wbl_value_reg <= wr_value;
        end
    end

    // Never take an item while the byte memory is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) mem_busy |-> !s_tready)
        else $error("item accepted during memory clearing pass");

    // A result appears only for an item that was in the execute stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s2_valid_reg) |-> $past(s1_valid_reg))
        else $error("result stage filled from an empty execute stage");

    // x0 is never reported as written
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[5:1] != 5'd0))
        else $error("write to x0 reported");

    // No memory access while the clearing pass owns the lanes
    assert property (@(posedge clk) disable iff (!rst_n) mem_ctl.en |-> !mem_busy)
        else $error("memory access during clearing pass");

endmodule
